// ----- hw/rtl/dli2c_pkg.sv -----
`timescale 1ns / 1ps

package dli2c_pkg;

  localparam int HOLD_W = 14;

  // Phase hold times in microseconds
  localparam logic [HOLD_W-1:0] HOLD_IDLE_HIGH  = 14'd10000;
  localparam logic [HOLD_W-1:0] HOLD_START_SDA  = 14'd100;
  localparam logic [HOLD_W-1:0] HOLD_CLK        = 14'd150;
  localparam logic [HOLD_W-1:0] HOLD_START_GAP  = 14'd2000;
  localparam logic [HOLD_W-1:0] HOLD_BIT_SETUP  = 14'd5;
  localparam logic [HOLD_W-1:0] HOLD_ACK_SETUP  = 14'd50;
  localparam logic [HOLD_W-1:0] HOLD_ACK_GAP    = 14'd1200;
  localparam logic [HOLD_W-1:0] HOLD_STOP_SETUP = 14'd300;
  localparam logic [HOLD_W-1:0] HOLD_RELEASE    = 14'd0;

  // Last phase index inside each segment
  localparam logic [2:0] START_LAST = 3'd3;
  localparam logic [2:0] BIT_LAST   = 3'd2;
  localparam logic [2:0] ACK_LAST   = 3'd2;
  localparam logic [2:0] STOP_LAST  = 3'd4;

  typedef enum logic [1:0] {
    SEG_START,
    SEG_BITS,
    SEG_ACK,
    SEG_STOP
  } seg_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    seg_t       seg;
    logic [2:0] sub;
    logic [2:0] bit_idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic in_command;
    logic final_pair;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/dli2c_ctrl.sv -----
`timescale 1ns / 1ps

module dli2c_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dli2c_pkg::status_t status,
  output dli2c_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_BITS  = 5'b00100,
    ST_ACK   = 5'b01000,
    ST_STOP  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [2:0] bit_r, bit_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    sub_nxt     = sub_r;
    bit_nxt     = bit_r;
    cmd.load    = in_tvalid && in_tready;
    cmd.emit    = (state_r != ST_IDLE) && status.out_free;
    cmd.sub     = sub_r;
    cmd.bit_idx = bit_r;
    cmd.seg     = dli2c_pkg::SEG_START;
    cmd.last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = status.in_command ? ST_BITS : ST_START;
          sub_nxt   = '0;
          bit_nxt   = '1;
        end
      end
      ST_START: begin
        cmd.seg = dli2c_pkg::SEG_START;
        if (cmd.emit) begin
          if (sub_r == dli2c_pkg::START_LAST) begin
            state_nxt = ST_BITS;
            sub_nxt   = '0;
          end else begin
            sub_nxt = 3'(sub_r + 3'd1);
          end
        end
      end
      ST_BITS: begin
        cmd.seg = dli2c_pkg::SEG_BITS;
        if (cmd.emit) begin
          if (sub_r == dli2c_pkg::BIT_LAST) begin
            sub_nxt = '0;
            if (bit_r == 3'd0) begin
              state_nxt = ST_ACK;
            end else begin
              bit_nxt = 3'(bit_r - 3'd1);
            end
          end else begin
            sub_nxt = 3'(sub_r + 3'd1);
          end
        end
      end
      ST_ACK: begin
        cmd.seg  = dli2c_pkg::SEG_ACK;
        cmd.last = (sub_r == dli2c_pkg::ACK_LAST) && !status.final_pair;
        if (cmd.emit) begin
          if (sub_r == dli2c_pkg::ACK_LAST) begin
            state_nxt = status.final_pair ? ST_STOP : ST_IDLE;
            sub_nxt   = '0;
          end else begin
            sub_nxt = 3'(sub_r + 3'd1);
          end
        end
      end
      ST_STOP: begin
        cmd.seg  = dli2c_pkg::SEG_STOP;
        cmd.last = (sub_r == dli2c_pkg::STOP_LAST);
        if (cmd.emit) begin
          if (sub_r == dli2c_pkg::STOP_LAST) begin
            state_nxt = ST_IDLE;
            sub_nxt   = '0;
          end else begin
            sub_nxt = 3'(sub_r + 3'd1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        sub_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sub_r   <= '0;
      bit_r   <= '1;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

// ----- hw/rtl/dli2c_datapath.sv -----
`timescale 1ns / 1ps

module dli2c_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dli2c_pkg::cmd_t    cmd,
  input  logic [15:0]        in_tdata,
  input  logic               in_tlast,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [23:0]        out_tdata,
  output logic               out_tlast,
  output dli2c_pkg::status_t status
);

  logic [7:0] left_r;
  logic [7:0] right_r;
  logic       final_r;
  logic       in_command_r;
  logic       left_last_r;
  logic       right_last_r;

  logic                         out_valid_r;
  logic                         scl_r, sda_l_r, sda_r_r, dd_r, cd_r, last_r;
  logic [dli2c_pkg::HOLD_W-1:0] hold_r;

  logic                         scl_nxt, sda_l_nxt, sda_r_nxt, dd_nxt, cd_nxt;
  logic [dli2c_pkg::HOLD_W-1:0] hold_nxt;
  logic                         bits_done;
  logic                         stop_done;

  assign status.in_command = in_command_r;
  assign status.final_pair = final_r;
  assign status.out_free   = !out_valid_r || out_tready;

  assign bits_done = cmd.emit && (cmd.seg == dli2c_pkg::SEG_BITS) &&
                     (cmd.bit_idx == 3'd0) && (cmd.sub == dli2c_pkg::BIT_LAST);
  assign stop_done = cmd.emit && (cmd.seg == dli2c_pkg::SEG_STOP) &&
                     (cmd.sub == dli2c_pkg::STOP_LAST);

  // Pin phase for the current segment and step
  always_comb begin
    scl_nxt   = 1'b0;
    sda_l_nxt = 1'b1;
    sda_r_nxt = 1'b1;
    dd_nxt    = 1'b1;
    cd_nxt    = 1'b1;
    hold_nxt  = dli2c_pkg::HOLD_RELEASE;
    case (cmd.seg)
      dli2c_pkg::SEG_START: begin
        case (cmd.sub)
          3'd0: begin
            scl_nxt  = 1'b1;
            hold_nxt = dli2c_pkg::HOLD_IDLE_HIGH;
          end
          3'd1: begin
            scl_nxt   = 1'b1;
            sda_l_nxt = 1'b0;
            sda_r_nxt = 1'b0;
            hold_nxt  = dli2c_pkg::HOLD_START_SDA;
          end
          3'd2: begin
            sda_l_nxt = 1'b0;
            sda_r_nxt = 1'b0;
            hold_nxt  = dli2c_pkg::HOLD_CLK;
          end
          default: begin
            hold_nxt = dli2c_pkg::HOLD_START_GAP;
          end
        endcase
      end
      dli2c_pkg::SEG_BITS: begin
        sda_l_nxt = left_r[cmd.bit_idx];
        sda_r_nxt = right_r[cmd.bit_idx];
        case (cmd.sub)
          3'd0: hold_nxt = dli2c_pkg::HOLD_BIT_SETUP;
          3'd1: begin
            scl_nxt  = 1'b1;
            hold_nxt = dli2c_pkg::HOLD_CLK;
          end
          default: hold_nxt = dli2c_pkg::HOLD_CLK;
        endcase
      end
      dli2c_pkg::SEG_ACK: begin
        sda_l_nxt = left_last_r;
        sda_r_nxt = right_last_r;
        dd_nxt    = 1'b0;
        case (cmd.sub)
          3'd0: hold_nxt = dli2c_pkg::HOLD_ACK_SETUP;
          3'd1: begin
            scl_nxt  = 1'b1;
            hold_nxt = dli2c_pkg::HOLD_CLK;
          end
          default: hold_nxt = dli2c_pkg::HOLD_ACK_GAP;
        endcase
      end
      default: begin
        case (cmd.sub)
          3'd0: begin
            sda_l_nxt = left_last_r;
            sda_r_nxt = right_last_r;
            hold_nxt  = dli2c_pkg::HOLD_STOP_SETUP;
          end
          3'd1: begin
            sda_l_nxt = 1'b0;
            sda_r_nxt = 1'b0;
            hold_nxt  = dli2c_pkg::HOLD_CLK;
          end
          3'd2: begin
            scl_nxt   = 1'b1;
            sda_l_nxt = 1'b0;
            sda_r_nxt = 1'b0;
            hold_nxt  = dli2c_pkg::HOLD_CLK;
          end
          3'd3: begin
            scl_nxt  = 1'b1;
            hold_nxt = dli2c_pkg::HOLD_IDLE_HIGH;
          end
          default: begin
            // release everything
            scl_nxt  = 1'b1;
            dd_nxt   = 1'b0;
            cd_nxt   = 1'b0;
            hold_nxt = dli2c_pkg::HOLD_RELEASE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_tdata[7:0];
      right_r <= in_tdata[15:8];
      final_r <= in_tlast;
    end
    if (cmd.emit) begin
      scl_r   <= scl_nxt;
      sda_l_r <= sda_l_nxt;
      sda_r_r <= sda_r_nxt;
      dd_r    <= dd_nxt;
      cd_r    <= cd_nxt;
      hold_r  <= hold_nxt;
      last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      in_command_r <= 1'b0;
      left_last_r  <= 1'b1;
      right_last_r <= 1'b1;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        in_command_r <= 1'b1;
      end else if (stop_done) begin
        in_command_r <= 1'b0;
      end
      if (bits_done) begin
        left_last_r  <= left_r[0];
        right_last_r <= right_r[0];
      end else if (stop_done) begin
        left_last_r  <= 1'b1;
        right_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'b0, hold_r, cd_r, dd_r, sda_r_r, sda_l_r, scl_r};

endmodule

// ----- hw/rtl/dual_lane_i2c_write_master.sv -----
`timescale 1ns / 1ps

// Dual-lane I2C write master: each accepted item is a byte pair, one byte per
// SDA line, both lines sharing one SCL. The block answers with pin phases
// (levels, drive enables, hold time in us), one phase per cycle while
// out_tready is high, set by the controller stepping one phase per clock.
// A pair gives 27 phases (24 bit, 3 acknowledge), plus 4 start phases on the
// first pair of a command and 5 stop phases on a pair marked tlast, so an
// item gives 27 to 36 phases. The next item is taken once the last phase of
// the current one has entered the output register. tlast on the result marks
// the last phase of each item. Acknowledges are not sampled.

module dual_lane_i2c_write_master (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // left_byte[7:0], right_byte[15:8]
  input  logic        in_tlast,   // final_pair
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // clock_level[0], left_data_level[1],
                                  // right_data_level[2], data_drive[3],
                                  // clock_drive[4], hold_us[18:5], zero[23:19]
  output logic        out_tlast   // end_of_run
);

  dli2c_pkg::cmd_t    cmd;
  dli2c_pkg::status_t status;

  dli2c_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dli2c_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .status     (status)
  );

  a_no_emit_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && cmd.emit))
    else $error("phase issued while waiting for an item");

  a_load_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("controller stayed idle after taking an item");

  a_release_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[4]) |-> (out_tlast && !out_tdata[3]))
    else $error("clock released on a phase that does not end a run");

  a_stop_clears_command: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.seg == dli2c_pkg::SEG_STOP && cmd.last) |=> !status.in_command)
    else $error("command still open after stop");

endmodule
